[src/nntr_pkg.sv]
// Shared types and constants of the nearest-neighbor tile resampler.
// Holds opcodes, status codes, register indexes and controller/datapath structs.
// Depends on nothing.
package nntr_pkg;

    // Field widths of the stream words and of the configuration port.
    localparam int LOAD_INDEX_W = 12;
    localparam int PIXEL_W      = 32;
    localparam int COORD_W      = 6;
    localparam int STATUS_W     = 2;
    localparam int AIDX_W       = 20;
    localparam int S_TDATA_W    = 56;
    localparam int M_TDATA_W    = 56;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 20;

    // Configuration register widths.
    localparam int SIZE_W = 7;
    localparam int TPR_W  = 11;
    localparam int SLOT_W = 20;

    // Divider lanes work on 20-bit dividends, one quotient bit per step.
    localparam int DIV_NUM_W = 20;
    localparam int DIV_STEPS = 20;
    localparam int STEP_W    = 5;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILES_PER_ROW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_SIZE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_SLOT     = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [SIZE_W-1:0] RST_SRC_WIDTH     = 7'd16;
    localparam logic [SIZE_W-1:0] RST_SRC_HEIGHT    = 7'd16;
    localparam logic [SIZE_W-1:0] RST_TILE_SIZE     = 7'd16;
    localparam logic [TPR_W-1:0]  RST_TILES_PER_ROW = 11'd16;
    localparam logic [TPR_W-1:0]  RST_ATLAS_SIZE    = 11'd256;
    localparam logic [SLOT_W-1:0] RST_TILE_SLOT     = 20'd0;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_FETCH = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_OUTSIDE = 2'd2
    } t_status;

    typedef struct packed {
        logic [SIZE_W-1:0] src_width;
        logic [SIZE_W-1:0] src_height;
        logic [SIZE_W-1:0] tile_size;
        logic [TPR_W-1:0]  tiles_per_row;
        logic [TPR_W-1:0]  atlas_size;
        logic [SLOT_W-1:0] tile_slot;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_we;   // write the accepted load word into the store
        logic    capture;   // capture the fetch coordinates
        logic    div_load;  // start the three divider lanes
        logic    mod_load;  // latch the quotient that wraps the source index
        logic    div_step;  // one restoring step on every lane
        logic    mul1;      // first product stage
        logic    mul2;      // second product stage
        logic    aidx_en;   // final atlas index add
        logic    rd_en;     // read the pixel store
        logic    rd_mod;    // read at the wrapped index
        logic    out_load;  // load the output register
        t_status status;    // status of the result being loaded
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic outside;
        logic sidx_small;
    } t_sts;

endpackage

[src/nntr_cfg.sv]
// Configuration register file of the tile resampler.
// Depends on nntr_pkg for register indexes, widths and reset values.
module nntr_cfg
    import nntr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_wr_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write; indexes past the list are dropped.
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_wr_index)
                REG_SRC_WIDTH:     n_cfg.src_width     = i_wr_data[SIZE_W-1:0];
                REG_SRC_HEIGHT:    n_cfg.src_height    = i_wr_data[SIZE_W-1:0];
                REG_TILE_SIZE:     n_cfg.tile_size     = i_wr_data[SIZE_W-1:0];
                REG_TILES_PER_ROW: n_cfg.tiles_per_row = i_wr_data[TPR_W-1:0];
                REG_ATLAS_SIZE:    n_cfg.atlas_size    = i_wr_data[TPR_W-1:0];
                REG_TILE_SLOT:     n_cfg.tile_slot     = i_wr_data[SLOT_W-1:0];
                default:           n_cfg               = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_width     <= RST_SRC_WIDTH;
            r_cfg.src_height    <= RST_SRC_HEIGHT;
            r_cfg.tile_size     <= RST_TILE_SIZE;
            r_cfg.tiles_per_row <= RST_TILES_PER_ROW;
            r_cfg.atlas_size    <= RST_ATLAS_SIZE;
            r_cfg.tile_slot     <= RST_TILE_SLOT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[src/nntr_div.sv]
// One restoring divider lane: one quotient bit per step, dividend shifted out MSB first.
// Depends on nntr_pkg for the dividend width.
module nntr_div
    import nntr_pkg::*;
#(
    parameter int REM_W = 11
) (
    input  logic                 i_clk,
    input  logic                 i_load,
    input  logic                 i_step,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [REM_W-1:0]     i_den,
    output logic [DIV_NUM_W-1:0] o_quo,
    output logic [REM_W-1:0]     o_rem
);

    logic [DIV_NUM_W-1:0] r_num;
    logic [REM_W-1:0]     r_rem;
    logic [REM_W-1:0]     r_den;
    logic [REM_W:0]       w_shift;
    logic [REM_W:0]       w_diff;
    logic                 w_qbit;

    // Bring down the next dividend bit and try a subtract.
    assign w_shift = {r_rem, r_num[DIV_NUM_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_qbit  = (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (i_step) begin
            r_num <= {r_num[DIV_NUM_W-2:0], w_qbit};
            r_rem <= w_qbit ? w_diff[REM_W-1:0] : w_shift[REM_W-1:0];
        end
    end

    assign o_quo = r_num;
    assign o_rem = r_rem;

endmodule

[src/nntr_dp.sv]
// Datapath of the tile resampler: pixel store, divider lanes, products and output word.
// Depends on nntr_pkg and on nntr_div.
module nntr_dp
    import nntr_pkg::*;
#(
    parameter int MAX_SRC_PIXELS = 4096,
    parameter int MAX_TILE       = 64,
    parameter int ADDR_W         = 12,
    parameter int REM_W          = 13
) (
    input  logic                    i_clk,
    input  t_cfg                    i_cfg,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic [LOAD_INDEX_W-1:0] i_load_index,
    input  logic [PIXEL_W-1:0]      i_load_pixel,
    input  logic [COORD_W-1:0]      i_dst_x,
    input  logic [COORD_W-1:0]      i_dst_y,
    output t_status                 o_status,
    output logic [AIDX_W-1:0]       o_atlas_index,
    output logic [PIXEL_W-1:0]      o_out_pixel
);

    // The source index stays below src_width*src_height, so 14 bits hold it.
    // It is wrapped by a reciprocal multiply that is exact over that range.
    localparam int SIDX_W     = 2*SIZE_W;
    localparam int RECIP_W    = SIDX_W + 1;
    localparam int WRAP_SHIFT = SIDX_W + $clog2(MAX_SRC_PIXELS);
    localparam int WRAP_MUL   = ((1 << WRAP_SHIFT) + MAX_SRC_PIXELS - 1) / MAX_SRC_PIXELS;

    logic [PIXEL_W-1:0]   r_mem [MAX_SRC_PIXELS];
    logic [PIXEL_W-1:0]   r_rd_data;
    logic [COORD_W-1:0]   r_dx;
    logic [COORD_W-1:0]   r_dy;
    logic [DIV_NUM_W-1:0] r_rowt;
    logic [DIV_NUM_W-1:0] r_colt;
    logic [DIV_NUM_W-1:0] r_syw;
    logic [DIV_NUM_W-1:0] r_pitch;
    logic [DIV_NUM_W-1:0] r_sidx;
    logic [SIDX_W-1:0]    r_wrap_quo;
    logic [AIDX_W-1:0]    r_aidx;
    t_status              r_o_status;
    logic [AIDX_W-1:0]    r_o_aidx;
    logic [PIXEL_W-1:0]   r_o_pixel;

    logic [SIZE_W-1:0]         w_tile;
    logic [2*TPR_W-1:0]        w_tpr_sq;
    logic [2*SIZE_W-2:0]       w_x_prod;
    logic [2*SIZE_W-2:0]       w_y_prod;
    logic [DIV_NUM_W-1:0]      w_x_quo;
    logic [DIV_NUM_W-1:0]      w_y_quo;
    logic [DIV_NUM_W-1:0]      w_r_quo;
    logic [REM_W-1:0]          w_x_rem;
    logic [REM_W-1:0]          w_y_rem;
    logic [REM_W-1:0]          w_r_rem;
    logic [SIDX_W+RECIP_W-1:0] w_wrap_prod;
    logic [SIDX_W-1:0]         w_wrap_idx;
    logic                      w_load_ok;
    logic [ADDR_W-1:0]         w_rd_addr;

    // Effective tile edge, clamped to the largest supported tile.
    assign w_tile = (32'(i_cfg.tile_size) > 32'(MAX_TILE)) ? SIZE_W'(MAX_TILE)
                                                           : i_cfg.tile_size;

    // Checks on the captured fetch; the atlas-full test takes priority in the controller.
    assign w_tpr_sq       = (2*TPR_W)'(i_cfg.tiles_per_row) * (2*TPR_W)'(i_cfg.tiles_per_row);
    assign o_sts.full     = ((2*TPR_W)'(i_cfg.tile_slot) >= w_tpr_sq);
    assign o_sts.outside  = ({1'b0, r_dx} >= w_tile) || ({1'b0, r_dy} >= w_tile);
    assign o_sts.sidx_small = (32'(r_sidx) < 32'(MAX_SRC_PIXELS));

    // Dividends of the two coordinate lanes.
    assign w_x_prod = (2*SIZE_W-1)'(r_dx) * (2*SIZE_W-1)'(i_cfg.src_width);
    assign w_y_prod = (2*SIZE_W-1)'(r_dy) * (2*SIZE_W-1)'(i_cfg.src_height);

    nntr_div #(.REM_W(REM_W)) u_div_x (
        .i_clk  (i_clk),
        .i_load (i_cmd.div_load),
        .i_step (i_cmd.div_step),
        .i_num  (DIV_NUM_W'(w_x_prod)),
        .i_den  (REM_W'(w_tile)),
        .o_quo  (w_x_quo),
        .o_rem  (w_x_rem)
    );

    nntr_div #(.REM_W(REM_W)) u_div_y (
        .i_clk  (i_clk),
        .i_load (i_cmd.div_load),
        .i_step (i_cmd.div_step),
        .i_num  (DIV_NUM_W'(w_y_prod)),
        .i_den  (REM_W'(w_tile)),
        .o_quo  (w_y_quo),
        .o_rem  (w_y_rem)
    );

    // The slot lane splits the tile slot into tile row and tile column.
    nntr_div #(.REM_W(REM_W)) u_div_r (
        .i_clk  (i_clk),
        .i_load (i_cmd.div_load),
        .i_step (i_cmd.div_step),
        .i_num  (DIV_NUM_W'(i_cfg.tile_slot)),
        .i_den  (REM_W'(i_cfg.tiles_per_row)),
        .o_quo  (w_r_quo),
        .o_rem  (w_r_rem)
    );

    // Coordinates of the fetch in progress.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_dx <= i_dst_x;
            r_dy <= i_dst_y;
        end
    end

    // Product stages; everything is kept modulo the 20-bit atlas index range.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_rowt <= w_r_quo * DIV_NUM_W'(w_tile);
            r_colt <= DIV_NUM_W'(w_r_rem) * DIV_NUM_W'(w_tile) + DIV_NUM_W'(r_dx);
            r_syw  <= w_y_quo * DIV_NUM_W'(i_cfg.src_width);
        end
        if (i_cmd.mul2) begin
            r_pitch <= (r_rowt + DIV_NUM_W'(r_dy)) * DIV_NUM_W'(i_cfg.atlas_size);
            r_sidx  <= r_syw + w_x_quo;
        end
        if (i_cmd.aidx_en) begin
            r_aidx <= AIDX_W'(r_pitch + r_colt);
        end
    end

    // Source index wrap: quotient by reciprocal multiply, then the remainder.
    assign w_wrap_prod = (SIDX_W+RECIP_W)'(r_sidx[SIDX_W-1:0])
                       * (SIDX_W+RECIP_W)'(WRAP_MUL);
    assign w_wrap_idx  = r_sidx[SIDX_W-1:0]
                       - SIDX_W'(r_wrap_quo * SIDX_W'(MAX_SRC_PIXELS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.mod_load) begin
            r_wrap_quo <= SIDX_W'(w_wrap_prod >> WRAP_SHIFT);
        end
    end

    // Pixel store: one write port for loads, one registered read port for fetches.
    assign w_load_ok = (32'(i_load_index) < 32'(MAX_SRC_PIXELS));
    assign w_rd_addr = i_cmd.rd_mod ? ADDR_W'(w_wrap_idx) : ADDR_W'(r_sidx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we && w_load_ok) begin
            r_mem[ADDR_W'(i_load_index)] <= i_load_pixel;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Output word register; error results carry zero index and pixel.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_status <= i_cmd.status;
            if (i_cmd.status == ST_OK) begin
                r_o_aidx  <= r_aidx;
                r_o_pixel <= r_rd_data;
            end else begin
                r_o_aidx  <= '0;
                r_o_pixel <= '0;
            end
        end
    end

    assign o_status      = r_o_status;
    assign o_atlas_index = r_o_aidx;
    assign o_out_pixel   = r_o_pixel;

endmodule

[src/nntr_ctrl.sv]
// Controller of the tile resampler: sequences loads and fetches, owns the stream handshakes.
// Depends on nntr_pkg for the command and status structs.
module nntr_ctrl
    import nntr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_opcode i_opcode,
    output t_cmd    o_cmd,
    input  t_sts    i_sts,
    output logic    o_out_valid,
    input  logic    i_out_ready
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_CHECK = 8'b00000010,
        S_DIV   = 8'b00000100,
        S_MUL1  = 8'b00001000,
        S_MUL2  = 8'b00010000,
        S_ADDR  = 8'b00100000,
        S_READ  = 8'b01000000,
        S_RESP  = 8'b10000000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_status           r_status;
    t_status           n_status;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              w_accept;
    logic              w_out_free;
    logic              w_last_step;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_last_step = (r_step == STEP_W'(DIV_STEPS - 1));

    // Next state and commands.
    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_status = r_status;
        o_cmd    = '0;
        o_cmd.status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_opcode == OP_FETCH) begin
                        o_cmd.capture = 1'b1;
                        n_state = S_CHECK;
                    end else begin
                        o_cmd.load_we = 1'b1;
                    end
                end
            end
            S_CHECK: begin
                if (i_sts.full) begin
                    n_status = ST_FULL;
                    n_state  = S_RESP;
                end else if (i_sts.outside) begin
                    n_status = ST_OUTSIDE;
                    n_state  = S_RESP;
                end else begin
                    o_cmd.div_load = 1'b1;
                    n_status = ST_OK;
                    n_step   = '0;
                    n_state  = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step = r_step + 1'b1;
                if (w_last_step) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state = S_ADDR;
            end
            S_ADDR: begin
                o_cmd.aidx_en = 1'b1;
                if (i_sts.sidx_small) begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_RESP;
                end else begin
                    o_cmd.mod_load = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_mod = 1'b1;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid: set when a word is loaded, cleared when it is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[src/nearest_neighbor_tile_resampler.sv]
// Top level of the nearest-neighbor tile resampler.
// Depends on nntr_pkg, nntr_cfg, nntr_ctrl and nntr_dp.
//
//   Channel   Direction  Handshake               Payload
//   s (in)    input      i_s_tvalid/o_s_tready   tdata: index, pixel, dst_x, dst_y; tuser: opcode
//   m (out)   output     o_m_tvalid/i_m_tready   tdata: atlas_index, out_pixel; tuser: status
//   cfg       input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// A load word is written to the store on acceptance. A fetch word holds the block through
// the 20-step divider lanes and the product stages; a fetch whose source index runs past
// the store passes through the extra read state to wrap it with a reciprocal multiply.
// An atlas-full or out-of-tile fetch goes from the check straight to the response. Reset
// is synchronous and active low; the pixel store is not cleared. A stalled result waits in
// the output register while the next word is accepted; a later fetch waits only if it is full.
module nearest_neighbor_tile_resampler
    import nntr_pkg::*;
#(
    parameter int MAX_SRC_PIXELS = 4096,
    parameter int MAX_TILE       = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input words.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,  // load_index, load_pixel, dst_x, dst_y
    input  logic                  i_s_tuser,  // opcode
    // Result words.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,  // atlas_index, out_pixel, zero pad
    output logic [STATUS_W-1:0]   o_m_tuser,  // status
    // Configuration writes.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ADDR_W    = $clog2(MAX_SRC_PIXELS);
    localparam int SRC_CNT_W = $clog2(MAX_SRC_PIXELS + 1);
    localparam int REM_W     = (SRC_CNT_W > TPR_W) ? SRC_CNT_W : TPR_W;

    t_cfg                    w_cfg;
    t_cmd                    w_cmd;
    t_sts                    w_sts;
    t_opcode                 w_opcode;
    t_status                 w_status;
    logic [AIDX_W-1:0]       w_atlas_index;
    logic [PIXEL_W-1:0]      w_out_pixel;
    logic [LOAD_INDEX_W-1:0] w_load_index;
    logic [PIXEL_W-1:0]      w_load_pixel;
    logic [COORD_W-1:0]      w_dst_x;
    logic [COORD_W-1:0]      w_dst_y;

    // Unpack the input word, lowest field first.
    assign w_load_index = i_s_tdata[11:0];
    assign w_load_pixel = i_s_tdata[43:12];
    assign w_dst_x      = i_s_tdata[49:44];
    assign w_dst_y      = i_s_tdata[55:50];
    assign w_opcode     = t_opcode'(i_s_tuser);

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    nntr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    nntr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_opcode    (w_opcode),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready)
    );

    nntr_dp #(
        .MAX_SRC_PIXELS (MAX_SRC_PIXELS),
        .MAX_TILE       (MAX_TILE),
        .ADDR_W         (ADDR_W),
        .REM_W          (REM_W)
    ) u_dp (
        .i_clk         (i_clk),
        .i_cfg         (w_cfg),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_load_index  (w_load_index),
        .i_load_pixel  (w_load_pixel),
        .i_dst_x       (w_dst_x),
        .i_dst_y       (w_dst_y),
        .o_status      (w_status),
        .o_atlas_index (w_atlas_index),
        .o_out_pixel   (w_out_pixel)
    );

    // Pack the result word, lowest field first, padded to whole bytes.
    assign o_m_tdata = {4'd0, w_out_pixel, w_atlas_index};
    assign o_m_tuser = w_status;

endmodule

[test/nntr_fetch_checker.sv]
// Result checker for the nearest-neighbor tile resampler testbench.
// Watches the input, result and configuration channels, predicts every fetch and
// compares it with the result words. Depends on nntr_pkg.
`timescale 1ns / 1ps

module nntr_fetch_checker
    import nntr_pkg::*;
#(
    parameter int SRC_DEPTH = 4096,
    parameter int TILE_CAP  = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input words as seen on the block's slave side.
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,  // load_index, load_pixel, dst_x, dst_y
    input  logic                  i_s_tuser,  // opcode
    // Result words as seen on the block's master side.
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [M_TDATA_W-1:0]  i_m_tdata,  // atlas_index, out_pixel, zero pad
    input  logic [STATUS_W-1:0]   i_m_tuser,  // status
    // Configuration writes.
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Fetches still waiting for their result, and mismatches so far.
    output int                    o_outstanding,
    output int                    o_mismatches
);

    // Bit positions of the fields in the input and result words.
    localparam int PIX_LSB = LOAD_INDEX_W;
    localparam int DX_LSB  = PIX_LSB + PIXEL_W;
    localparam int DY_LSB  = DX_LSB + COORD_W;
    localparam int OUT_LSB = AIDX_W;
    localparam int PAD_LSB = AIDX_W + PIXEL_W;
    localparam int PAD_W   = M_TDATA_W - PAD_LSB;

    localparam t_cfg RESET_CFG = '{
        RST_SRC_WIDTH, RST_SRC_HEIGHT, RST_TILE_SIZE,
        RST_TILES_PER_ROW, RST_ATLAS_SIZE, RST_TILE_SLOT
    };

    typedef struct packed {
        t_status             status;
        logic [AIDX_W-1:0]   atlas_index;
        logic [PIXEL_W-1:0]  pixel;
    } t_fetch_result;

    t_cfg                live_cfg = RESET_CFG;
    logic [PIXEL_W-1:0]  source_pixels [SRC_DEPTH];
    t_fetch_result       awaited_results [$];

    // Nearest-neighbor pick of one tile pixel under the current settings.
    function automatic t_fetch_result resample_fetch(input logic [COORD_W-1:0] dx,
                                                     input logic [COORD_W-1:0] dy);
        t_fetch_result r;
        logic [63:0]   tile_edge, sx, sy, src_idx, col, row, linear;
        r = '0;
        // The slot check wins over the coordinate check.
        if (64'(live_cfg.tile_slot) >=
            64'(live_cfg.tiles_per_row) * 64'(live_cfg.tiles_per_row)) begin
            r.status = ST_FULL;
            return r;
        end
        tile_edge = (live_cfg.tile_size > TILE_CAP) ? 64'(TILE_CAP)
                                                    : 64'(live_cfg.tile_size);
        // A zero tile edge puts every coordinate outside.
        if (64'(dx) >= tile_edge || 64'(dy) >= tile_edge) begin
            r.status = ST_OUTSIDE;
            return r;
        end
        sx      = 64'(dx) * 64'(live_cfg.src_width) / tile_edge;
        sy      = 64'(dy) * 64'(live_cfg.src_height) / tile_edge;
        src_idx = (sy * 64'(live_cfg.src_width) + sx) % 64'(SRC_DEPTH);
        col     = 64'(live_cfg.tile_slot) % 64'(live_cfg.tiles_per_row);
        row     = 64'(live_cfg.tile_slot) / 64'(live_cfg.tiles_per_row);
        linear  = (row * tile_edge + 64'(dy)) * 64'(live_cfg.atlas_size)
                + col * tile_edge + 64'(dx);
        r.status      = ST_OK;
        r.atlas_index = linear[AIDX_W-1:0];
        r.pixel       = source_pixels[int'(src_idx)];
        return r;
    endfunction

    // Results are retired before new fetches are queued, so a word accepted at the
    // same edge as a result never pairs with it.
    always @(posedge i_clk) begin : watch_channels
        t_fetch_result want;
        if (!i_rst_n) begin
            live_cfg = RESET_CFG;
            awaited_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("result word with no fetch waiting: tuser %0d tdata %h",
                           i_m_tuser, i_m_tdata);
                    o_mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_m_tuser);
                        o_mismatches++;
                    end
                    if (i_m_tdata[AIDX_W-1:0] !== want.atlas_index) begin
                        $error("atlas_index: expected %h, got %h",
                               want.atlas_index, i_m_tdata[AIDX_W-1:0]);
                        o_mismatches++;
                    end
                    if (i_m_tdata[OUT_LSB +: PIXEL_W] !== want.pixel) begin
                        $error("out_pixel: expected %h, got %h",
                               want.pixel, i_m_tdata[OUT_LSB +: PIXEL_W]);
                        o_mismatches++;
                    end
                    if (i_m_tdata[PAD_LSB +: PAD_W] !== '0) begin
                        $error("tdata pad: expected %h, got %h",
                               {PAD_W{1'b0}}, i_m_tdata[PAD_LSB +: PAD_W]);
                        o_mismatches++;
                    end
                end
            end

            // Register writes keep only the bits of the register's width.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_SRC_WIDTH:     live_cfg.src_width     = i_cfg_data[SIZE_W-1:0];
                    REG_SRC_HEIGHT:    live_cfg.src_height    = i_cfg_data[SIZE_W-1:0];
                    REG_TILE_SIZE:     live_cfg.tile_size     = i_cfg_data[SIZE_W-1:0];
                    REG_TILES_PER_ROW: live_cfg.tiles_per_row = i_cfg_data[TPR_W-1:0];
                    REG_ATLAS_SIZE:    live_cfg.atlas_size    = i_cfg_data[TPR_W-1:0];
                    REG_TILE_SLOT:     live_cfg.tile_slot     = i_cfg_data[SLOT_W-1:0];
                    default: ;
                endcase
            end

            // A load fills the store; a fetch queues its expected result.
            if (i_s_tvalid && i_s_tready) begin
                if (t_opcode'(i_s_tuser) == OP_LOAD) begin
                    source_pixels[i_s_tdata[LOAD_INDEX_W-1:0]] = i_s_tdata[PIX_LSB +: PIXEL_W];
                end else begin
                    awaited_results.push_back(resample_fetch(i_s_tdata[DX_LSB +: COORD_W],
                                                             i_s_tdata[DY_LSB +: COORD_W]));
                end
            end
        end
        o_outstanding = awaited_results.size();
    end

endmodule

[test/tb_nearest_neighbor_tile_resampler.sv]
// Testbench top of the nearest-neighbor tile resampler: clock, reset, stimulus and verdict.
// Depends on nntr_pkg, nearest_neighbor_tile_resampler and nntr_fetch_checker.
`timescale 1ns / 1ps

module tb_nearest_neighbor_tile_resampler;
    import nntr_pkg::*;

    localparam int SRC_DEPTH       = 4096;
    localparam int TILE_CAP        = 64;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 165;
    localparam int STEADY_PHASE    = 5;
    localparam int DRAIN_CYCLES    = 64;
    localparam int IDLE_PERCENT    = 31;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]  i_s_tdata   = '0;  // load_index, load_pixel, dst_x, dst_y
    logic                  i_s_tuser   = 1'b0;  // opcode
    logic                  i_m_tready  = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [M_TDATA_W-1:0]  o_m_tdata;  // atlas_index, out_pixel, zero pad
    logic [STATUS_W-1:0]   o_m_tuser;  // status
    logic                  o_cfg_ready;
    int                    outstanding;
    int                    mismatches;

    // Settings as last written, used to steer the stimulus only.
    t_cfg cfg_shadow = '{
        RST_SRC_WIDTH, RST_SRC_HEIGHT, RST_TILE_SIZE,
        RST_TILES_PER_ROW, RST_ATLAS_SIZE, RST_TILE_SLOT
    };
    bit   loaded [SRC_DEPTH];
    bit   steady = 1'b0;

    nearest_neighbor_tile_resampler #(
        .MAX_SRC_PIXELS (SRC_DEPTH),
        .MAX_TILE       (TILE_CAP)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    nntr_fetch_checker #(
        .SRC_DEPTH (SRC_DEPTH),
        .TILE_CAP  (TILE_CAP)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_m_tuser     (o_m_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_outstanding (outstanding),
        .o_mismatches  (mismatches)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // The result side stalls at random, except during the steady stretch.
    always @(posedge i_clk) begin
        i_m_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Hard stop in case the block hangs.
    initial begin
        #(10_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Store entry a fetch will read, or -1 when it ends in an error status.
    function automatic int source_entry(input int dx, input int dy);
        int w, h, t, tpr, slot;
        w    = cfg_shadow.src_width;
        h    = cfg_shadow.src_height;
        tpr  = cfg_shadow.tiles_per_row;
        slot = cfg_shadow.tile_slot;
        t    = (cfg_shadow.tile_size > TILE_CAP) ? TILE_CAP : cfg_shadow.tile_size;
        if (slot >= tpr * tpr || dx >= t || dy >= t)
            return -1;
        return ((dy * h / t) * w + dx * w / t) % SRC_DEPTH;
    endfunction

    // Offers one input word after a random idle gap and waits for its handshake.
    task automatic send_word(input t_opcode op, input logic [LOAD_INDEX_W-1:0] idx,
                             input logic [PIXEL_W-1:0] pix,
                             input logic [COORD_W-1:0] dx, input logic [COORD_W-1:0] dy);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {dy, dx, pix, idx};
        i_s_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic load_word(input int idx, input logic [PIXEL_W-1:0] pix);
        loaded[idx] = 1'b1;
        send_word(OP_LOAD, LOAD_INDEX_W'(idx), pix, COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // Fills the source entry first when the fetch would read one never written.
    task automatic fetch_word(input int dx, input int dy);
        int entry;
        entry = source_entry(dx, dy);
        if (entry >= 0 && !loaded[entry])
            load_word(entry, $urandom);
        send_word(OP_FETCH, LOAD_INDEX_W'($urandom), $urandom, COORD_W'(dx), COORD_W'(dy));
    endtask

    // Waits until every fetch has returned and the block has settled.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write; bits above the register's width sometimes carry noise.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        logic [CFG_DATA_W-1:0] keep, data;
        case (idx)
            REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_TILE_SIZE: keep = 20'h0007F;
            REG_TILES_PER_ROW, REG_ATLAS_SIZE:            keep = 20'h007FF;
            default:                                      keep = 20'hFFFFF;
        endcase
        data = CFG_DATA_W'(value) & keep;
        case (idx)
            REG_SRC_WIDTH:     cfg_shadow.src_width     = data[SIZE_W-1:0];
            REG_SRC_HEIGHT:    cfg_shadow.src_height    = data[SIZE_W-1:0];
            REG_TILE_SIZE:     cfg_shadow.tile_size     = data[SIZE_W-1:0];
            REG_TILES_PER_ROW: cfg_shadow.tiles_per_row = data[TPR_W-1:0];
            REG_ATLAS_SIZE:    cfg_shadow.atlas_size    = data[TPR_W-1:0];
            default:           cfg_shadow.tile_slot     = data[SLOT_W-1:0];
        endcase
        if ($urandom_range(1) == 1)
            data = data | (CFG_DATA_W'($urandom) & ~keep);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Drains the block, then writes all six registers.
    task automatic apply_config(input int w, input int h, input int t,
                                input int tpr, input int atlas, input int slot);
        drain();
        write_reg(REG_SRC_WIDTH, w);
        write_reg(REG_SRC_HEIGHT, h);
        write_reg(REG_TILE_SIZE, t);
        write_reg(REG_TILES_PER_ROW, tpr);
        write_reg(REG_ATLAS_SIZE, atlas);
        write_reg(REG_TILE_SLOT, slot);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int w, h, t, tpr, atlas, slot, t_eff, area, top_slot;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset settings: pixel extremes, corners and
        // coordinates just outside the tile.
        load_word(0, 32'hFFFF_FFFF);
        load_word(SRC_DEPTH - 1, 32'h0000_0000);
        load_word(255, 32'hA5C3_5A3C);
        fetch_word(0, 0);
        fetch_word(15, 15);
        fetch_word(16, 0);
        fetch_word(0, 16);
        fetch_word(63, 63);

        // Smallest geometry, then the largest with the last slot of the atlas.
        apply_config(1, 1, 1, 1, 1, 0);
        fetch_word(0, 0);
        fetch_word(1, 1);
        apply_config(64, 64, 64, 1024, 1024, 1048575);
        fetch_word(63, 63);
        fetch_word(0, 0);

        // Full atlas: no tiles at all, then a slot just past the last tile.
        apply_config(16, 16, 16, 0, 256, 0);
        fetch_word(0, 0);
        apply_config(16, 16, 16, 2, 256, 4);
        fetch_word(1, 1);

        // Zero tile edge puts everything outside the tile.
        apply_config(16, 16, 0, 16, 256, 0);
        fetch_word(0, 0);

        // Oversized tile and source: the source index wraps around the store.
        apply_config(127, 127, 127, 2047, 2047, 3);
        fetch_word(63, 63);
        fetch_word(32, 40);

        // Random settings per phase; most stay in range, some reach past it.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            w     = ($urandom_range(99) < 15) ? $urandom_range(127) : $urandom_range(64, 1);
            h     = ($urandom_range(99) < 15) ? $urandom_range(127) : $urandom_range(64, 1);
            t     = ($urandom_range(99) < 15) ? $urandom_range(127) : $urandom_range(64, 1);
            tpr   = ($urandom_range(99) < 15) ? $urandom_range(2047) : $urandom_range(1024, 1);
            atlas = ($urandom_range(99) < 15) ? $urandom_range(2047) : $urandom_range(1024, 1);
            top_slot = (tpr * tpr - 1 > 1048575) ? 1048575 : tpr * tpr - 1;
            if (tpr > 0 && $urandom_range(99) < 85)
                slot = $urandom_range(top_slot);
            else
                slot = $urandom_range(1048575);
            apply_config(w, h, t, tpr, atlas, slot);
            steady = (p == STEADY_PHASE);

            t_eff = (cfg_shadow.tile_size > TILE_CAP) ? TILE_CAP : cfg_shadow.tile_size;
            area  = int'(cfg_shadow.src_width) * int'(cfg_shadow.src_height);
            if (area > SRC_DEPTH)
                area = SRC_DEPTH;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if ($urandom_range(99) < 35) begin
                    // Loads mostly land inside the configured source image.
                    if (area > 0 && $urandom_range(99) < 70)
                        load_word($urandom_range(area - 1), $urandom);
                    else
                        load_word($urandom_range(SRC_DEPTH - 1), $urandom);
                end else if (t_eff > 0 && $urandom_range(99) < 85) begin
                    fetch_word($urandom_range(t_eff - 1), $urandom_range(t_eff - 1));
                end else begin
                    fetch_word($urandom_range(63), $urandom_range(63));
                end
            end
            steady = 1'b0;
        end

        drain();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
